// ===== rtl/core/grid_path_cell_walker_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef GRID_PATH_CELL_WALKER_UNIT_DEFINES_SVH
`define GRID_PATH_CELL_WALKER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GPCW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define GPCW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/gpcw_pkg.sv =====
package gpcw_pkg;

  // defaults for the top level parameters
  localparam int MAX_PASSES_DEF  = 64;
  localparam int FRAC_BITS_DEF   = 16;

  // fixed formats
  localparam int IN_FRAC         = 16;
  localparam int NO_STEP_SPAN    = 256;
  localparam int SLOPE_CAP_BITS  = 24;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int CELL_SIZE_RESET = 128;

  // coordinates and coordinate differences
  typedef logic signed [35:0] crd_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X     = 3'd0,
    REG_MIN_Y     = 3'd1,
    REG_MAX_X     = 3'd2,
    REG_MAX_Y     = 3'd3,
    REG_CELL_SIZE = 3'd4
  } cfg_reg_t;

  // setup operations, run in this order
  typedef enum logic [3:0] {
    OP_CLIP0 = 4'd0,   // x = min_x
    OP_CLIP1 = 4'd1,   // y = max_y
    OP_CLIP2 = 4'd2,   // x = max_x
    OP_CLIP3 = 4'd3,   // y = min_y
    OP_OX    = 4'd4,
    OP_OY    = 4'd5,
    OP_DX    = 4'd6,
    OP_DY    = 4'd7,
    OP_IX    = 4'd8,
    OP_IY    = 4'd9,
    OP_SLX   = 4'd10,
    OP_SLY   = 4'd11,
    OP_MX    = 4'd12,
    OP_MY    = 4'd13
  } op_t;

  // sequencer states
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SETUP = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_STORE = 7'b0010000,
    ST_NEXT  = 7'b0100000,
    ST_WALK  = 7'b1000000
  } state_t;

endpackage

// ===== rtl/core/grid_path_cell_walker_unit.sv =====
// Grid cell walker. A beat on the slave side carries a segment (start, end) in
// 16.16 map units; the block answers with the ordered grid cells it crosses,
// one master beat per cell, tlast on the final one, and nothing when the start
// is outside the box. Setup runs on a single bit-serial multiply/divide unit:
// edge clips (a multiply and a divide each), eight divisions (cell of a
// point, intercepts, slopes) and two intercept corrections (a multiply each)
// come before the first cell; the walk then gives one cell per cycle while
// the master side keeps up. s_tready is high only while idle; the final
// cell may still sit in the output register when the next segment is taken.
module grid_path_cell_walker_unit #(
  parameter int MAX_PASSES = gpcw_pkg::MAX_PASSES_DEF,
  parameter int FRAC_BITS  = gpcw_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [gpcw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gpcw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [127:0]                     s_tdata,   // start_x, start_y, end_x, end_y
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [31:0]                      m_tdata,   // cell_col, cell_row
  output logic                             m_tlast
);
  import gpcw_pkg::*;

  localparam int PW   = 68 + FRAC_BITS;   // product / dividend / quotient
  localparam int AW   = 36 + FRAC_BITS;   // multiplicand
  localparam int MB   = 36;               // multiplier bits
  localparam int DVW  = 36;               // divisor
  localparam int IW   = FRAC_BITS + 34;   // intercepts
  localparam int SW   = FRAC_BITS + 26;   // slopes
  localparam int FW   = FRAC_BITS + 1;    // fractions
  localparam int CNTW = $clog2(PW + 1);
  localparam int NW   = $clog2(MAX_PASSES + 1);

  function automatic crd_t sx36(input logic signed [31:0] v);
    return {{4{v[31]}}, v};
  endfunction

  // configuration
  logic signed [31:0] min_x, min_y, max_x, max_y;
  logic [15:0]        cell_size;

  // segment and walk state
  crd_t               sx, sy, tx, ty;
  logic [31:0]        ox, oy, dx, dy, cx, cy;
  logic signed [IW-1:0] ix, iy;
  logic signed [SW-1:0] isx, isy;
  logic [FW-1:0]      fx, fy;
  logic signed [1:0]  stx, sty;
  logic [NW-1:0]      nval;

  // shared multiply/divide unit
  logic [PW-1:0]      prod;
  logic [AW-1:0]      mul_a;
  logic [MB-1:0]      mul_b;
  logic [DVW-1:0]     dv;
  logic [DVW-1:0]     rem;
  logic               eng_neg;
  logic               do_div;
  logic [CNTW-1:0]    cnt;

  op_t                op;
  state_t             st;

  // helpers
  logic [15:0]        cs_eff;
  logic [DVW-1:0]     span;
  crd_t               in_sx, in_sy, in_tx, in_ty, in_tx_n, in_ty_n, adx, ady;
  logic               start_in, end_in;
  crd_t               c_edge, c_qa, c_qb, c_pa, c_pb, c_den, c_num, c_denm, c_numm;
  crd_t               c_diff, c_dmag, c_qn, c_res;
  logic               c_use, c_xaxis;
  crd_t               t_v, t_lo, t_hi, t_vc, t_d, i_d;
  logic [31:0]        s_c0, s_c1;
  crd_t               s_dax, s_dot;
  logic [35:0]        s_den, s_mag;
  logic signed [IW-1:0] s_icpt;
  logic [FW-1:0]      s_fp, one;
  logic [PW-1:0]      cap, qc;
  logic signed [SW-1:0] sl_val, no_step;
  logic [IW-1:0]      mq;
  logic signed [IW-1:0] m_res;
  logic [AW-1:0]      m_amag;
  logic [SW-1:0]      m_smag;
  logic [DVW:0]       d_try;
  logic               d_ge;
  logic [IW-1:0]      ixm, iym, ixs, iys, icx_f, icy_f;
  logic [31:0]        icx, icy;
  logic               done, lastp, obuf_free;

  assign s_tready = (st == ST_IDLE);
  assign cs_eff   = (cell_size == 16'd0) ? 16'd1 : cell_size;
  assign span     = {{(DVW-16){1'b0}}, cs_eff} << IN_FRAC;
  assign one      = FW'(1) << FRAC_BITS;
  assign cap      = PW'(1) << (FRAC_BITS + SLOPE_CAP_BITS);
  assign no_step  = SW'(NO_STEP_SPAN) << FRAC_BITS;

  // input check and end nudge
  always_comb begin
    in_sx    = sx36(s_tdata[31:0]);
    in_sy    = sx36(s_tdata[63:32]);
    in_tx    = sx36(s_tdata[95:64]);
    in_ty    = sx36(s_tdata[127:96]);
    start_in = (in_sx >= sx36(min_x)) && (in_sx <= sx36(max_x)) &&
               (in_sy >= sx36(min_y)) && (in_sy <= sx36(max_y));
    adx      = in_tx - sx36(min_x);
    if (adx < 0) adx = -adx;
    ady      = in_ty - sx36(min_y);
    if (ady < 0) ady = -ady;
    in_tx_n  = (adx < $signed(span)) ? in_tx + (crd_t'(1) <<< IN_FRAC) : in_tx;
    in_ty_n  = (ady < $signed(span)) ? in_ty + (crd_t'(1) <<< IN_FRAC) : in_ty;
    end_in   = (in_tx_n >= sx36(min_x)) && (in_tx_n <= sx36(max_x)) &&
               (in_ty_n >= sx36(min_y)) && (in_ty_n <= sx36(max_y));
  end

  // operand selection for the current setup operation
  always_comb begin
    c_xaxis = (op == OP_CLIP0) || (op == OP_CLIP2);
    case (op)
      OP_CLIP0: c_edge = sx36(min_x);
      OP_CLIP1: c_edge = sx36(max_y);
      OP_CLIP2: c_edge = sx36(max_x);
      default:  c_edge = sx36(min_y);
    endcase
    c_qa   = c_xaxis ? sx : sy;
    c_qb   = c_xaxis ? sy : sx;
    c_pa   = c_xaxis ? tx : ty;
    c_pb   = c_xaxis ? ty : tx;
    c_den  = c_pa - c_qa;
    c_num  = c_edge - c_qa;
    c_denm = (c_den < 0) ? -c_den : c_den;
    c_numm = (c_den < 0) ? -c_num : c_num;
    c_use  = (c_den != 0) && (c_numm >= 0) && (c_numm <= c_denm);
    c_diff = c_pb - c_qb;
    c_dmag = (c_diff < 0) ? -c_diff : c_diff;
    c_qn   = $signed(prod[35:0]);
    c_res  = eng_neg ? -c_qn : c_qn;

    // cell of a point
    case (op)
      OP_OX:   begin t_v = sx; t_lo = sx36(min_x); t_hi = sx36(max_x); end
      OP_OY:   begin t_v = sy; t_lo = sx36(min_y); t_hi = sx36(max_y); end
      OP_DX:   begin t_v = tx; t_lo = sx36(min_x); t_hi = sx36(max_x); end
      default: begin t_v = ty; t_lo = sx36(min_y); t_hi = sx36(max_y); end
    endcase
    if (t_v < t_lo) t_vc = t_lo;
    else if (t_v >= t_hi) t_vc = t_hi - (crd_t'(1) <<< IN_FRAC);
    else t_vc = t_v;
    t_d = t_vc - t_lo;
    i_d = (op == OP_IX) ? sx - sx36(min_x) : sy - sx36(min_y);

    // slope setup
    if (op == OP_SLX) begin
      s_c0 = ox; s_c1 = dx; s_dax = tx - sx; s_dot = ty - sy; s_icpt = ix;
    end else begin
      s_c0 = oy; s_c1 = dy; s_dax = ty - sy; s_dot = tx - sx; s_icpt = iy;
    end
    s_den  = (s_dax < 0) ? $unsigned(-s_dax) : $unsigned(s_dax);
    s_mag  = (s_dot < 0) ? $unsigned(-s_dot) : $unsigned(s_dot);
    s_fp   = {1'b0, s_icpt[FRAC_BITS-1:0]};
    qc     = (prod > cap) ? cap : prod;
    sl_val = eng_neg ? -$signed(qc[SW-1:0]) : $signed(qc[SW-1:0]);

    // intercept correction
    m_smag = (op == OP_MX) ? ((isx < 0) ? $unsigned(-isx) : $unsigned(isx))
                           : ((isy < 0) ? $unsigned(-isy) : $unsigned(isy));
    m_amag = {{(AW-SW){1'b0}}, m_smag};
    mq     = prod[FRAC_BITS +: IW];
    m_res  = eng_neg ? -$signed(mq) : $signed(mq);

    // one restoring divide step
    d_try  = {rem, prod[PW-1]};
    d_ge   = (d_try >= {1'b0, dv});
  end

  // walk: cell of each intercept, truncated toward zero
  always_comb begin
    ixm   = ix[IW-1] ? $unsigned(-ix) : $unsigned(ix);
    iym   = iy[IW-1] ? $unsigned(-iy) : $unsigned(iy);
    ixs   = ixm >> FRAC_BITS;
    iys   = iym >> FRAC_BITS;
    icx_f = ix[IW-1] ? (~ixs + 1'b1) : ixs;
    icy_f = iy[IW-1] ? (~iys + 1'b1) : iys;
    icx   = icx_f[31:0];
    icy   = icy_f[31:0];
    done  = (cx == dx) && (cy == dy);
    lastp = done || (nval == NW'(MAX_PASSES - 1));
    obuf_free = !m_tvalid || m_tready;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_x     <= '0;
      min_y     <= '0;
      max_x     <= '0;
      max_y     <= '0;
      cell_size <= 16'(CELL_SIZE_RESET);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIN_X:     min_x     <= cfg_data;
        REG_MIN_Y:     min_y     <= cfg_data;
        REG_MAX_X:     max_x     <= cfg_data;
        REG_MAX_Y:     max_y     <= cfg_data;
        REG_CELL_SIZE: cell_size <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer, shared unit and walk
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ST_IDLE;
      op       <= OP_CLIP0;
      m_tvalid <= 1'b0;
    end else begin
      // outside the walk a taken beat empties the output register
      if (m_tvalid && m_tready && (st != ST_WALK)) m_tvalid <= 1'b0;
      case (st)
        ST_IDLE: begin
          if (s_tvalid) begin
            sx <= in_sx;
            sy <= in_sy;
            tx <= in_tx_n;
            ty <= in_ty_n;
            op <= end_in ? OP_OX : OP_CLIP0;
            if (start_in) st <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          cnt <= '0;
          rem <= '0;
          case (op)
            OP_CLIP0, OP_CLIP1, OP_CLIP2, OP_CLIP3: begin
              if (c_use) begin
                mul_a   <= {{(AW-36){1'b0}}, $unsigned(c_numm)};
                mul_b   <= $unsigned(c_dmag);
                prod    <= '0;
                dv      <= $unsigned(c_denm);
                eng_neg <= (c_diff < 0);
                do_div  <= 1'b1;
                st      <= ST_MUL;
              end else begin
                st <= ST_NEXT;
              end
            end
            OP_OX, OP_OY, OP_DX, OP_DY: begin
              prod <= (t_d < 0) ? '0 : {{(PW-36){1'b0}}, $unsigned(t_d)};
              dv   <= span;
              st   <= ST_DIV;
            end
            OP_IX, OP_IY: begin
              prod <= {{(PW-36){1'b0}}, $unsigned(i_d)} << FRAC_BITS;
              dv   <= span;
              st   <= ST_DIV;
            end
            OP_SLX, OP_SLY: begin
              eng_neg <= (s_dot < 0);
              if (s_c1 == s_c0) begin
                if (op == OP_SLX) begin
                  stx <= 2'sd0; isy <= no_step; fy <= one;
                end else begin
                  sty <= 2'sd0; isx <= no_step; fx <= one;
                end
                st <= ST_NEXT;
              end else if (s_den == '0) begin
                prod <= cap;
                st   <= ST_STORE;
              end else begin
                prod <= {{(PW-36){1'b0}}, s_mag} << FRAC_BITS;
                dv   <= s_den;
                st   <= ST_DIV;
              end
            end
            default: begin
              // intercept correction: |slope| * fraction
              mul_a   <= m_amag;
              mul_b   <= (op == OP_MX) ? {{(MB-FW){1'b0}}, fx} : {{(MB-FW){1'b0}}, fy};
              prod    <= '0;
              eng_neg <= (op == OP_MX) ? (isx < 0) : (isy < 0);
              do_div  <= 1'b0;
              st      <= ST_MUL;
            end
          endcase
        end
        ST_MUL: begin
          prod  <= (prod << 1) + (mul_b[MB-1] ? {{(PW-AW){1'b0}}, mul_a} : '0);
          mul_b <= mul_b << 1;
          cnt   <= (cnt == CNTW'(MB - 1)) ? '0 : cnt + 1'b1;
          if (cnt == CNTW'(MB - 1)) begin
            rem <= '0;
            st  <= do_div ? ST_DIV : ST_STORE;
          end
        end
        ST_DIV: begin
          rem  <= d_ge ? DVW'(d_try - {1'b0, dv}) : d_try[DVW-1:0];
          prod <= {prod[PW-2:0], d_ge};
          cnt  <= cnt + 1'b1;
          if (cnt == CNTW'(PW - 1)) st <= ST_STORE;
        end
        ST_STORE: begin
          st <= ST_NEXT;
          case (op)
            OP_CLIP0, OP_CLIP1, OP_CLIP2, OP_CLIP3: begin
              if (c_xaxis) begin
                tx <= c_edge; ty <= c_qb + c_res;
              end else begin
                ty <= c_edge; tx <= c_qb + c_res;
              end
            end
            OP_OX:  ox <= prod[31:0];
            OP_OY:  oy <= prod[31:0];
            OP_DX:  dx <= prod[31:0];
            OP_DY:  dy <= prod[31:0];
            OP_IX:  ix <= $signed(prod[IW-1:0]);
            OP_IY:  iy <= $signed(prod[IW-1:0]);
            OP_SLX: begin
              isy <= sl_val;
              stx <= (s_c1 > s_c0) ? 2'sd1 : -2'sd1;
              fy  <= (s_c1 > s_c0) ? one - s_fp : s_fp;
            end
            OP_SLY: begin
              isx <= sl_val;
              sty <= (s_c1 > s_c0) ? 2'sd1 : -2'sd1;
              fx  <= (s_c1 > s_c0) ? one - s_fp : s_fp;
            end
            OP_MX:  ix <= ix + m_res;
            default: iy <= iy + m_res;
          endcase
        end
        ST_NEXT: begin
          if (op == OP_MY) begin
            cx   <= ox;
            cy   <= oy;
            nval <= '0;
            st   <= ST_WALK;
          end else begin
            op <= op_t'(op + 4'd1);
            st <= ST_SETUP;
          end
        end
        ST_WALK: begin
          if (obuf_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {cy[15:0], cx[15:0]};
            m_tlast  <= lastp;
            nval     <= nval + 1'b1;
            if (lastp) begin
              st <= ST_IDLE;
            end else if (cy == icy) begin
              cx <= cx + {{30{stx[1]}}, stx};
              iy <= iy + {{(IW-SW){isy[SW-1]}}, isy};
            end else if (cx == icx) begin
              cy <= cy + {{30{sty[1]}}, sty};
              ix <= ix + {{(IW-SW){isx[SW-1]}}, isx};
            end
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/gpcw_checker.sv =====
`include "grid_path_cell_walker_unit_defines.svh"

module gpcw_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  // a stalled beat holds
  `GPCW_ASSERT_NXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled cell beat changed")

  // a pending cell that is not the final one means the walk is still running
  `GPCW_ASSERT_IMP(a_busy_mid_walk, m_tvalid && !m_tlast, !s_tready, "input taken in the middle of a walk")

  // the walk refills the output register right after a non-final beat
  `GPCW_ASSERT_NXT(a_walk_refill, m_tvalid && m_tready && !m_tlast, m_tvalid, "gap after a non-final cell")

endmodule

bind grid_path_cell_walker_unit gpcw_checker u_gpcw_checker (.*);

// ===== dv/grid_path_cell_walker_unit_tb.sv =====
`timescale 1ns / 1ps

module grid_path_cell_walker_unit_tb;
  import gpcw_pkg::*;

  localparam int PASS_CAP   = 64;
  localparam int CELL_FRAC  = 16;
  localparam int SETTLE     = 1600;
  localparam int STALL_CAP  = 20000;
  localparam longint ONE_IN = 64'sd1 << IN_FRAC;
  localparam longint I32_LO = -64'sd2147483648;
  localparam longint I32_HI = 64'sd2147483647;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [15:0] col;
    logic [15:0] row;
    logic        last;
  } cell_beat_t;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [31:0]  m_tdata;
  logic         m_tlast;

  // shadow of the box registers
  longint      box_min_x, box_min_y, box_max_x, box_max_y;
  bit [15:0]   box_cell;

  logic [127:0] seg_q[$];
  cell_beat_t   cell_exp[$];
  int           errors = 0;
  int           idle_cycles = 0;
  int           src_gap;
  int           snk_gap;
  bit           calm;

  grid_path_cell_walker_unit uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- cell walk predictor ----------------

  function automatic longint sx32(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  // a*b/c toward zero, quotient kept to 62 bits
  function automatic longint scale_div(longint a, longint b, longint c);
    longint unsigned ua, ub, q;
    logic [127:0] prod;
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    prod = {64'd0, ua} * {64'd0, ub};
    q = 64'(prod / {64'd0, c});
    q &= 64'h3FFF_FFFF_FFFF_FFFF;
    return ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
  endfunction

  // move the end onto line pa == edge_v when the crossing lies on the segment
  function automatic void clip_edge(input longint edge_v, input longint qa, input longint qb,
                                    inout longint pa, inout longint pb);
    longint den, num;
    den = pa - qa;
    num = edge_v - qa;
    if (den == 0) return;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (num < 0 || num > den) return;
    pb = qb + scale_div(num, pb - qb, den);
    pa = edge_v;
  endfunction

  function automatic bit [31:0] cell_of(longint v, longint lo, longint hi, longint span);
    longint d;
    if (v < lo) v = lo;
    else if (v >= hi) v = hi - ONE_IN;
    d = v - lo;
    if (d < 0) return 32'd0;
    return 32'(d / span);
  endfunction

  function automatic bit [31:0] whole_cell(longint v);
    longint unsigned m;
    m = (v < 0 ? -v : v) >> CELL_FRAC;
    return v < 0 ? 32'(-m) : 32'(m);
  endfunction

  function automatic void axis_rate(input bit [31:0] c0, input bit [31:0] c1,
                                    input longint icpt, input longint d_axis,
                                    input longint d_other, output int stp,
                                    output longint slope, output longint frac);
    longint one, fpart;
    longint unsigned mag, den, q, cap;
    one = 64'sd1 << CELL_FRAC;
    fpart = icpt & (one - 1);
    cap = 64'd1 << (CELL_FRAC + SLOPE_CAP_BITS);
    if (c1 == c0) begin
      stp = 0;
      slope = longint'(NO_STEP_SPAN) << CELL_FRAC;
      frac = one;
      return;
    end
    den = d_axis < 0 ? -d_axis : d_axis;
    mag = d_other < 0 ? -d_other : d_other;
    q = den != 0 ? (mag << CELL_FRAC) / den : cap;
    if (q > cap) q = cap;
    slope = d_other < 0 ? -longint'(q) : longint'(q);
    if (c1 > c0) begin
      stp = 1;
      frac = one - fpart;
    end else begin
      stp = -1;
      frac = fpart;
    end
  endfunction

  function automatic void walk_segment(logic [127:0] seg);
    longint sx, sy, tx, ty, span, ix, iy, isx, isy, fx, fy;
    int stx, sty, n;
    bit [31:0] ox, oy, dx, dy, cx, cy;
    bit done;
    cell_beat_t b;
    sx = sx32(seg[31:0]);
    sy = sx32(seg[63:32]);
    tx = sx32(seg[95:64]);
    ty = sx32(seg[127:96]);
    span = longint'(box_cell == 0 ? 16'd1 : box_cell) << IN_FRAC;
    if (!(sx >= box_min_x && sx <= box_max_x && sy >= box_min_y && sy <= box_max_y)) return;
    // nudge off the origin lines
    if ((tx - box_min_x < 0 ? box_min_x - tx : tx - box_min_x) < span) tx += ONE_IN;
    if ((ty - box_min_y < 0 ? box_min_y - ty : ty - box_min_y) < span) ty += ONE_IN;
    if (!(tx >= box_min_x && tx <= box_max_x && ty >= box_min_y && ty <= box_max_y)) begin
      clip_edge(box_min_x, sx, sy, tx, ty);
      clip_edge(box_max_y, sy, sx, ty, tx);
      clip_edge(box_max_x, sx, sy, tx, ty);
      clip_edge(box_min_y, sy, sx, ty, tx);
    end
    ox = cell_of(sx, box_min_x, box_max_x, span);
    oy = cell_of(sy, box_min_y, box_max_y, span);
    dx = cell_of(tx, box_min_x, box_max_x, span);
    dy = cell_of(ty, box_min_y, box_max_y, span);
    ix = longint'((u64_t'(sx - box_min_x) << CELL_FRAC) / u64_t'(span));
    iy = longint'((u64_t'(sy - box_min_y) << CELL_FRAC) / u64_t'(span));
    axis_rate(ox, dx, ix, tx - sx, ty - sy, stx, isy, fy);
    axis_rate(oy, dy, iy, ty - sy, tx - sx, sty, isx, fx);
    ix += scale_div(fx, isx, 64'sd1 << CELL_FRAC);
    iy += scale_div(fy, isy, 64'sd1 << CELL_FRAC);
    cx = ox;
    cy = oy;
    n = 0;
    while (n < PASS_CAP) begin
      done = (cx == dx && cy == dy);
      b.col = cx[15:0];
      b.row = cy[15:0];
      b.last = done || n == PASS_CAP - 1;
      cell_exp.push_back(b);
      n++;
      if (done) break;
      if (cy == whole_cell(iy)) begin
        cx = cx + 32'(stx);
        iy += isy;
      end else if (cx == whole_cell(ix)) begin
        cy = cy + 32'(sty);
        ix += isx;
      end
    end
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic longint rnd_between(longint lo, longint hi);
    longint t;
    longint unsigned r;
    if (hi < lo) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    r = {$urandom, $urandom};
    return lo + longint'(r % u64_t'(hi - lo + 1));
  endfunction

  function automatic logic [31:0] pick_coord(longint lo, longint hi);
    longint m;
    int k;
    k = $urandom_range(0, 9);
    m = (longint'(box_cell) << IN_FRAC) * 4;
    if (k < 7) return 32'(rnd_between(lo, hi));
    if (k < 9) begin
      lo = lo - m < I32_LO ? I32_LO : lo - m;
      hi = hi + m > I32_HI ? I32_HI : hi + m;
      return 32'(rnd_between(lo, hi));
    end
    return $urandom;
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 9);
    if (calm || k < 6) return 0;
    if (k < 9) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_seg(longint ax, longint ay, longint bx, longint by);
    seg_q.push_back({32'(by), 32'(bx), 32'(ay), 32'(ax)});
  endtask

  task automatic add_random(int count);
    repeat (count) begin
      seg_q.push_back({pick_coord(box_min_y, box_max_y), pick_coord(box_min_x, box_max_x),
                       pick_coord(box_min_y, box_max_y), pick_coord(box_min_x, box_max_x)});
    end
  endtask

  task automatic wait_quiet();
    while (seg_q.size() != 0 || s_tvalid || cell_exp.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_box(longint x0, longint y0, longint x1, longint y1, bit [15:0] cs);
    write_reg(REG_MIN_X, 32'(x0));
    write_reg(REG_MIN_Y, 32'(y0));
    write_reg(REG_MAX_X, 32'(x1));
    write_reg(REG_MAX_Y, 32'(y1));
    write_reg(REG_CELL_SIZE, {16'd0, cs});
    box_min_x = x0;
    box_min_y = y0;
    box_max_x = x1;
    box_max_y = y1;
    box_cell = cs;
  endtask

  // ---------------- segment driver ----------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      src_gap = 0;
    end else begin
      if (s_tvalid && s_tready) walk_segment(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (seg_q.size() != 0) begin
          s_tdata <= seg_q.pop_front();
          s_tvalid <= 1'b1;
          src_gap = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- cell monitor ----------------
  always @(posedge clk) begin
    cell_beat_t want;
    if (rst) begin
      m_tready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (cell_exp.size() == 0) begin
          $error("unexpected cell beat col=%0d row=%0d", m_tdata[15:0], m_tdata[31:16]);
          errors++;
        end else begin
          want = cell_exp.pop_front();
          if (m_tdata[15:0] !== want.col) begin
            $error("cell_col expected %0d got %0d", want.col, m_tdata[15:0]);
            errors++;
          end
          if (m_tdata[31:16] !== want.row) begin
            $error("cell_row expected %0d got %0d", want.row, m_tdata[31:16]);
            errors++;
          end
          if (m_tlast !== want.last) begin
            $error("last expected %0b got %0b", want.last, m_tlast);
            errors++;
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        m_tready <= 1'b0;
      end else begin
        snk_gap = pick_gap();
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------- test sequence ----------------
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    box_min_x = 0;
    box_min_y = 0;
    box_max_x = 0;
    box_max_y = 0;
    box_cell = 16'(CELL_SIZE_RESET);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset box is a single point at the origin
    add_seg(0, 0, 0, 0);
    add_seg(0, 0, I32_HI, I32_HI);
    add_seg(0, 0, I32_LO, I32_LO);
    add_seg(ONE_IN, 0, 0, 0);
    add_seg(0, -1, 0, 0);
    wait_quiet();

    // ordinary box; corners, nudge, clipping, axis-parallel runs
    set_box(-100 * ONE_IN, -50 * ONE_IN, 400 * ONE_IN, 300 * ONE_IN, 16'd32);
    add_seg(-100 * ONE_IN, -50 * ONE_IN, -100 * ONE_IN, -50 * ONE_IN);
    add_seg(400 * ONE_IN, 300 * ONE_IN, I32_LO, I32_LO);
    add_seg(0, 0, 350 * ONE_IN, 0);
    add_seg(0, 0, 0, 280 * ONE_IN);
    add_seg(10 * ONE_IN, 10 * ONE_IN, 900 * ONE_IN, 700 * ONE_IN);
    add_seg(399 * ONE_IN, 299 * ONE_IN, -90 * ONE_IN, -40 * ONE_IN);
    add_seg(0, 0, I32_HI, I32_LO);
    add_seg(0, 0, 5 * ONE_IN, -49 * ONE_IN);
    add_seg(-101 * ONE_IN, 0, 0, 0);
    add_random(12);
    // hold back the rest until the walks so far have drained
    while (seg_q.size() != 0 || s_tvalid || cell_exp.size() != 0) @(posedge clk);
    add_random(15);
    wait_quiet();

    // widest box, widest cells
    set_box(I32_LO, I32_LO, I32_HI, I32_HI, 16'hFFFF);
    add_seg(I32_LO, I32_LO, I32_HI, I32_HI);
    add_seg(I32_HI, I32_HI, I32_LO, I32_LO);
    add_seg(I32_LO, I32_HI, I32_HI, I32_LO);
    calm = 1'b1;
    add_random(25);
    wait_quiet();
    calm = 1'b0;

    // unit cells, long walks up to the pass cap
    set_box(0, 0, 60 * ONE_IN, 60 * ONE_IN, 16'd1);
    add_seg(0, 0, 60 * ONE_IN, 60 * ONE_IN);
    add_seg(60 * ONE_IN, 0, 0, 59 * ONE_IN);
    add_seg(ONE_IN / 2, 3 * ONE_IN, 59 * ONE_IN, ONE_IN / 3);
    add_random(30);
    wait_quiet();

    // inverted box takes nothing
    set_box(100 * ONE_IN, 100 * ONE_IN, -100 * ONE_IN, -100 * ONE_IN, 16'd128);
    add_random(8);
    wait_quiet();

    // small odd cells around the origin
    set_box(-200 * ONE_IN, -200 * ONE_IN, 200 * ONE_IN, 200 * ONE_IN, 16'd7);
    add_random(30);
    wait_quiet();

    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
